### hw/rtl/mck_pkg.sv
// ----------------------------------------------------------------------------
// Morse keyer package
// Shared item types, timing constants and the ITU character code table.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned DurW      = 19;
  localparam int unsigned PatW      = 6;
  localparam int unsigned LenW      = 3;
  localparam int unsigned IdxW      = 6;

  localparam logic [TicksW-1:0] ElementReset = 16'd100;
  localparam logic [CharW-1:0]  CaseFold     = 8'd32;
  localparam logic [IdxW-1:0]   DigitBase    = 6'd26;
  localparam logic [IdxW-1:0]   CommaIndex   = 6'd36;
  localparam logic [IdxW-1:0]   PeriodIndex  = 6'd37;

  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChComma  = 8'h2C;
  localparam logic [CharW-1:0] ChPeriod = 8'h2E;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ = 8'h7A;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             first_of_message;
  } in_item_t;

  typedef struct packed {
    logic            lamp_on;
    logic [DurW-1:0] duration_ticks;
    logic            last;
  } out_item_t;

  typedef enum logic [1:0] {
    ELEM_ONE,
    ELEM_TWO,
    ELEM_THREE,
    ELEM_SIX
  } elem_t;

  typedef struct packed {
    logic            is_symbol;
    logic            is_space;
    logic [LenW-1:0] len;
    logic [PatW-1:0] pattern;
  } dec_t;

  // Returns {length, pattern}; the pattern is left-aligned, first element in
  // the top bit, with a one meaning a dash.
  function automatic logic [LenW+PatW-1:0] code_entry(input logic [IdxW-1:0] idx);
    logic [LenW-1:0] len;
    logic [PatW-1:0] bits;
    len  = 3'd1;
    bits = 6'd0;
    case (idx)
      6'd0:  begin len = 3'd2; bits = 6'd1;  end
      6'd1:  begin len = 3'd4; bits = 6'd8;  end
      6'd2:  begin len = 3'd4; bits = 6'd10; end
      6'd3:  begin len = 3'd3; bits = 6'd4;  end
      6'd4:  begin len = 3'd1; bits = 6'd0;  end
      6'd5:  begin len = 3'd4; bits = 6'd2;  end
      6'd6:  begin len = 3'd3; bits = 6'd6;  end
      6'd7:  begin len = 3'd4; bits = 6'd0;  end
      6'd8:  begin len = 3'd2; bits = 6'd0;  end
      6'd9:  begin len = 3'd4; bits = 6'd7;  end
      6'd10: begin len = 3'd3; bits = 6'd5;  end
      6'd11: begin len = 3'd4; bits = 6'd4;  end
      6'd12: begin len = 3'd2; bits = 6'd3;  end
      6'd13: begin len = 3'd2; bits = 6'd2;  end
      6'd14: begin len = 3'd3; bits = 6'd7;  end
      6'd15: begin len = 3'd4; bits = 6'd6;  end
      6'd16: begin len = 3'd4; bits = 6'd13; end
      6'd17: begin len = 3'd3; bits = 6'd2;  end
      6'd18: begin len = 3'd3; bits = 6'd0;  end
      6'd19: begin len = 3'd1; bits = 6'd1;  end
      6'd20: begin len = 3'd3; bits = 6'd1;  end
      6'd21: begin len = 3'd4; bits = 6'd1;  end
      6'd22: begin len = 3'd3; bits = 6'd3;  end
      6'd23: begin len = 3'd4; bits = 6'd9;  end
      6'd24: begin len = 3'd4; bits = 6'd11; end
      6'd25: begin len = 3'd4; bits = 6'd12; end
      6'd26: begin len = 3'd5; bits = 6'd31; end
      6'd27: begin len = 3'd5; bits = 6'd15; end
      6'd28: begin len = 3'd5; bits = 6'd7;  end
      6'd29: begin len = 3'd5; bits = 6'd3;  end
      6'd30: begin len = 3'd5; bits = 6'd1;  end
      6'd31: begin len = 3'd5; bits = 6'd0;  end
      6'd32: begin len = 3'd5; bits = 6'd16; end
      6'd33: begin len = 3'd5; bits = 6'd24; end
      6'd34: begin len = 3'd5; bits = 6'd28; end
      6'd35: begin len = 3'd5; bits = 6'd30; end
      6'd36: begin len = 3'd6; bits = 6'd51; end
      6'd37: begin len = 3'd6; bits = 6'd21; end
      default: begin len = 3'd1; bits = 6'd0; end
    endcase
    return {len, bits << (3'd6 - len)};
  endfunction

  // Segment length from element count; zero ticks count as one.
  function automatic logic [DurW-1:0] seg_ticks(input elem_t elems,
                                                input logic [TicksW-1:0] ticks);
    logic [TicksW-1:0] t;
    logic [DurW-1:0]   t1;
    logic [DurW-1:0]   t3;
    logic [DurW-1:0]   res;
    t   = (ticks == '0) ? 16'd1 : ticks;
    t1  = {3'b000, t};
    t3  = t1 + {2'b00, t, 1'b0};
    case (elems)
      ELEM_ONE:   res = t1;
      ELEM_TWO:   res = {2'b00, t, 1'b0};
      ELEM_THREE: res = t3;
      ELEM_SIX:   res = {t3[DurW-2:0], 1'b0};
      default:    res = t1;
    endcase
    return res;
  endfunction

endpackage

### hw/rtl/mck_stream_if.sv
// ----------------------------------------------------------------------------
// Morse keyer stream interface
// Valid/ready channel carrying one request payload per handshake.
// ----------------------------------------------------------------------------
interface mck_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/mck_char_decode.sv
// ----------------------------------------------------------------------------
// Morse keyer character decoder
// Folds case and maps a character to its code length and dot/dash pattern.
// ----------------------------------------------------------------------------
module mck_char_decode (
  input  logic [mck_pkg::CharW-1:0] char_code,
  output mck_pkg::dec_t             dec
);

  logic [mck_pkg::CharW-1:0]             c;
  logic [mck_pkg::IdxW-1:0]              idx;
  logic                                  hit;
  logic [mck_pkg::LenW+mck_pkg::PatW-1:0] entry;

  always_comb begin
    c = char_code;
    if (char_code inside {[mck_pkg::ChLowerA:mck_pkg::ChLowerZ]}) begin
      c = char_code - mck_pkg::CaseFold;
    end
    hit = 1'b1;
    idx = '0;
    if (c inside {[mck_pkg::ChUpperA:mck_pkg::ChUpperZ]}) begin
      idx = mck_pkg::IdxW'(c - mck_pkg::ChUpperA);
    end else if (c inside {[mck_pkg::ChZero:mck_pkg::ChNine]}) begin
      idx = mck_pkg::IdxW'(c - mck_pkg::ChZero) + mck_pkg::DigitBase;
    end else if (c == mck_pkg::ChComma) begin
      idx = mck_pkg::CommaIndex;
    end else if (c == mck_pkg::ChPeriod) begin
      idx = mck_pkg::PeriodIndex;
    end else begin
      hit = 1'b0;
    end
    entry         = mck_pkg::code_entry(idx);
    dec.is_symbol = hit;
    dec.is_space  = (c == mck_pkg::ChSpace);
    dec.len       = entry[mck_pkg::LenW+mck_pkg::PatW-1:mck_pkg::PatW];
    dec.pattern   = entry[mck_pkg::PatW-1:0];
  end

endmodule

### hw/rtl/mck_keyer_seq.sv
// ----------------------------------------------------------------------------
// Morse keyer segment sequencer
// Shifts the code pattern out one element at a time, a mark and a space for each,
// and registers each keying segment for the result channel.
// ----------------------------------------------------------------------------
module mck_keyer_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mck_pkg::TicksW-1:0] element_ticks,
  input  mck_pkg::dec_t              dec,
  mck_stream_if.sink                 in_ch,
  mck_stream_if.source               out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_MARK,
    S_SPACE,
    S_WORD
  } state_t;

  state_t                     state_r, state_nxt;
  logic [mck_pkg::PatW-1:0]   pat_r, pat_nxt;
  logic [mck_pkg::LenW-1:0]   cnt_r, cnt_nxt;
  logic                       prev_r, prev_nxt;
  logic                       out_valid_r, out_valid_nxt;
  mck_pkg::out_item_t         out_data_r, out_data_nxt;
  logic                       slot_free;
  logic                       prev_eff;
  mck_pkg::elem_t             elems;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign prev_eff     = prev_r && !in_ch.data.first_of_message;

  always_comb begin
    state_nxt     = state_r;
    pat_nxt       = pat_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    elems         = mck_pkg::ELEM_ONE;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          prev_nxt = prev_eff;
          if (dec.is_symbol) begin
            pat_nxt   = dec.pattern;
            cnt_nxt   = dec.len;
            prev_nxt  = 1'b1;
            state_nxt = prev_eff ? S_GAP : S_MARK;
          end else if (dec.is_space && prev_eff) begin
            prev_nxt  = 1'b0;
            state_nxt = S_WORD;
          end
        end
      end
      S_GAP: begin
        if (slot_free) begin
          elems         = mck_pkg::ELEM_TWO;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{lamp_on: 1'b0,
                            duration_ticks: mck_pkg::seg_ticks(elems, element_ticks),
                            last: 1'b0};
          state_nxt     = S_MARK;
        end
      end
      S_MARK: begin
        if (slot_free) begin
          elems         = pat_r[mck_pkg::PatW-1] ? mck_pkg::ELEM_THREE : mck_pkg::ELEM_ONE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{lamp_on: 1'b1,
                            duration_ticks: mck_pkg::seg_ticks(elems, element_ticks),
                            last: 1'b0};
          state_nxt     = S_SPACE;
        end
      end
      S_SPACE: begin
        if (slot_free) begin
          elems         = mck_pkg::ELEM_ONE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{lamp_on: 1'b0,
                            duration_ticks: mck_pkg::seg_ticks(elems, element_ticks),
                            last: (cnt_r == 3'd1)};
          pat_nxt       = {pat_r[mck_pkg::PatW-2:0], 1'b0};
          cnt_nxt       = cnt_r - 3'd1;
          state_nxt     = (cnt_r == 3'd1) ? S_IDLE : S_MARK;
        end
      end
      S_WORD: begin
        if (slot_free) begin
          elems         = mck_pkg::ELEM_SIX;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{lamp_on: 1'b0,
                            duration_ticks: mck_pkg::seg_ticks(elems, element_ticks),
                            last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    pat_r      <= pat_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hw/rtl/morse_code_keyer_top.sv
// ----------------------------------------------------------------------------
// Morse code keyer, top level
// Turns ASCII characters into ITU Morse keying segments.
// ----------------------------------------------------------------------------
// Each request on the input carries one character; the block answers with up
// to thirteen keying segments, each a lamp level and a length in timer ticks,
// and flags the last one. The sequencer shifts the code pattern out one dot or
// dash at a time and hands out one segment per cycle while the output is
// taken, and takes no new character until it has registered the last segment
// of the one before; a character that yields nothing frees the input in the
// cycle after it is taken. The element length register may be written only
// while the block is idle.
module morse_code_keyer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mck_pkg::TicksW-1:0] cfg_wdata,
  mck_stream_if.sink                 in_ch,
  mck_stream_if.source               out_ch
);

  logic [mck_pkg::TicksW-1:0] element_ticks_r;
  mck_pkg::dec_t              dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_ticks_r <= mck_pkg::ElementReset;
    end else if (cfg_we) begin
      element_ticks_r <= cfg_wdata;
    end
  end

  mck_char_decode u_decode (
    .char_code (in_ch.data.char_code),
    .dec       (dec)
  );

  mck_keyer_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .element_ticks (element_ticks_r),
    .dec           (dec),
    .in_ch         (in_ch),
    .out_ch        (out_ch)
  );

endmodule

### hw/rtl/mck_checker.sv
// ----------------------------------------------------------------------------
// Morse keyer port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module mck_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_lamp_on,
  input logic                      out_last,
  input logic [mck_pkg::DurW-1:0]  out_duration_ticks
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lamp_on) && $stable(out_last)
      && $stable(out_duration_ticks))
    else $error("result changed while stalled");

  a_busy_mid_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a character is still being sent");

  a_mark_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lamp_on |-> !out_last)
    else $error("character ended on a lit segment");

  a_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duration_ticks != '0)
    else $error("segment of zero length");

endmodule

bind morse_code_keyer_top mck_checker u_mck_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_lamp_on        (out_ch.data.lamp_on),
  .out_last           (out_ch.data.last),
  .out_duration_ticks (out_ch.data.duration_ticks)
);

### test/morse_code_keyer_top_tb.sv
// ----------------------------------------------------------------------------
// Morse code keyer testbench
// Sends characters to the keyer and checks every keying segment it returns
// against segments worked out in the bench from the ITU code table, across
// several element lengths and with random stalls on both channels.
// ----------------------------------------------------------------------------
module morse_code_keyer_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mck_pkg::*;

  localparam int DotElems     = 1;
  localparam int DashElems    = 3;
  localparam int CharGapElems = 2;
  localparam int WordGapElems = 6;
  localparam int SettleCycles = 16;
  localparam int QuietLimit   = 4000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [TicksW-1:0] cfg_wdata;

  mck_stream_if #(.payload_t(in_item_t))  in_ch ();
  mck_stream_if #(.payload_t(out_item_t)) out_ch ();

  morse_code_keyer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  out_item_t         pending_segs[$];
  logic [TicksW-1:0] elem_ticks;
  logic              after_symbol;
  int                send_idle = 24;
  int                recv_idle = 72;
  int                mismatches = 0;
  int                quiet_cycles = 0;

  function automatic string morse_pattern(input logic [CharW-1:0] c);
    case (c)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";
      "D": return "-..";    "E": return ".";      "F": return "..-.";
      "G": return "--.";    "H": return "....";   "I": return "..";
      "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";
      "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
      "S": return "...";    "T": return "-";      "U": return "..-";
      "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";
      "3": return "...--";  "4": return "....-";  "5": return ".....";
      "6": return "-....";  "7": return "--...";  "8": return "---..";
      "9": return "----.";
      ",": return "--..--"; ".": return ".-.-.-";
      default: return "";
    endcase
  endfunction

  function automatic void push_segment(input logic lamp, input int elems, input logic fin);
    out_item_t seg;
    logic [TicksW-1:0] t;
    t = (elem_ticks == '0) ? 16'd1 : elem_ticks;
    seg.lamp_on        = lamp;
    seg.duration_ticks = DurW'(elems * int'(t));
    seg.last           = fin;
    pending_segs.push_back(seg);
  endfunction

  // Queues the segments one character causes and returns how many there are.
  function automatic int key_char(input logic [CharW-1:0] code, input logic first);
    logic [CharW-1:0] c;
    string pat;
    int n;
    n = 0;
    c = code;
    if (first) after_symbol = 1'b0;
    if (c >= ChLowerA && c <= ChLowerZ) c = c - CaseFold;
    pat = morse_pattern(c);
    if (pat.len() == 0) begin
      if (c == ChSpace && after_symbol) begin
        push_segment(1'b0, WordGapElems, 1'b1);
        after_symbol = 1'b0;
        n = 1;
      end
      return n;
    end
    if (after_symbol) begin
      push_segment(1'b0, CharGapElems, 1'b0);
      n++;
    end
    for (int i = 0; i < pat.len(); i++) begin
      push_segment(1'b1, (pat[i] == "-") ? DashElems : DotElems, 1'b0);
      push_segment(1'b0, DotElems, i == pat.len() - 1);
      n += 2;
    end
    after_symbol = 1'b1;
    return n;
  endfunction

  task automatic send_char(input logic [CharW-1:0] ch, input logic first, output int n_segs);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {ch, first};
    do @(posedge clk); while (!in_ch.ready);
    n_segs = key_char(ch, first);
  endtask

  task automatic send_text(input string s, input logic first);
    int n;
    for (int i = 0; i < s.len(); i++) send_char(s[i], (i == 0) ? first : 1'b0, n);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_segs.size() != 0);
  endtask

  task automatic write_element_ticks(input logic [TicksW-1:0] value);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    elem_ticks  = value;
  endtask

  function automatic logic [CharW-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 35) return ChUpperA + CharW'($urandom_range(25));
    if (r < 55) return ChLowerA + CharW'($urandom_range(25));
    if (r < 70) return ChZero + CharW'($urandom_range(9));
    if (r < 76) return ($urandom_range(1) != 0) ? ChComma : ChPeriod;
    if (r < 90) return ChSpace;
    return CharW'($urandom);
  endfunction

  task automatic test_code_table();
    send_text("ETazQ09,.", 1'b1);
  endtask

  task automatic test_spacing();
    int n;
    send_char(ChSpace, 1'b0, n);
    send_char(ChSpace, 1'b0, n);
    send_char("#", 1'b0, n);
    send_char("A", 1'b0, n);
    send_char("K", 1'b0, n);
    send_char(8'hFF, 1'b0, n);
    send_char(8'h80, 1'b0, n);
    send_char("M", 1'b0, n);
    send_char("S", 1'b1, n);
    send_char(ChSpace, 1'b1, n);
    send_char(8'h00, 1'b0, n);
  endtask

  task automatic test_tick_extremes();
    write_element_ticks(16'hFFFF);
    send_text(", ", 1'b1);
    write_element_ticks(16'h0000);
    send_text("E ", 1'b0);
  endtask

  task automatic run_traffic(input int s_idle, input int r_idle,
                             input logic [TicksW-1:0] ticks, input int goal);
    int sent;
    int n;
    sent = 0;
    write_element_ticks(ticks);
    send_idle = s_idle;
    recv_idle = r_idle;
    while (sent < goal) begin
      if ($urandom_range(39) == 0) wait_drained();
      send_char(pick_char(), $urandom_range(15) == 0, n);
      if (n > 0) sent++;
    end
  endtask

  task automatic test_random_traffic();
    run_traffic(24, 72, TicksW'($urandom_range(65535, 1)), 60);
    run_traffic(72, 24, 16'd1, 60);
    run_traffic(0, 0, 16'hFFFF, 60);
  endtask

  always @(posedge clk) begin : check_segment
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_segs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected segment, got lamp=%0b ticks=%0d last=%0b", $time,
                 out_ch.data.lamp_on, out_ch.data.duration_ticks, out_ch.data.last);
      end else begin
        want = pending_segs.pop_front();
        if (out_ch.data.lamp_on !== want.lamp_on ||
            out_ch.data.duration_ticks !== want.duration_ticks ||
            out_ch.data.last !== want.last) begin
          mismatches++;
          $display("%0t: expected lamp=%0b ticks=%0d last=%0b, got lamp=%0b ticks=%0d last=%0b",
                   $time, want.lamp_on, want.duration_ticks, want.last,
                   out_ch.data.lamp_on, out_ch.data.duration_ticks, out_ch.data.last);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    elem_ticks    = ElementReset;
    after_symbol  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_code_table();
    test_spacing();
    test_tick_extremes();
    test_random_traffic();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
